>>> sv/spcr_pkg.sv
// Shared constants and helpers for the sphere pair collision response core.
package spcr_pkg;

   localparam int E_WIDTH           = 9;
   localparam int E_ONE             = 256;
   localparam int RESTITUTION_RESET = 205;
   localparam int COMPONENT_WIDTH   = 16;
   localparam int MASS_WIDTH        = 16;
   localparam int QUEUE_DEPTH       = 4;

   // Register values above one are treated as one.
   function automatic logic [E_WIDTH-1:0] clamp_e(input logic [E_WIDTH-1:0] raw);
      logic [E_WIDTH-1:0] res;
      res = (raw > E_WIDTH'(E_ONE)) ? E_WIDTH'(E_ONE) : raw;
      return res;
   endfunction

endpackage

>>> sv/spcr_front.sv
// Front part: accepts a sphere pair, runs the contact test and forms the coefficients.
module spcr_front #(
   parameter int C = spcr_pkg::COMPONENT_WIDTH,
   parameter int M = spcr_pkg::MASS_WIDTH,
   parameter int REQ_W = 256,
   parameter int EW = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [REQ_W-1:0]               in_data,
   input  logic [spcr_pkg::E_WIDTH-1:0]   restitution,
   output logic                           push,
   input  logic                           queue_full,
   output logic [EW-1:0]                  entry
);
   localparam int CW = M + 10;
   localparam int DW = M + 9;
   localparam int VW = 3 * C;
   localparam int SW = 2 * C + 2;

   logic [VW-1:0] pos_a, pos_b, vel_a, vel_b;
   logic [M-1:0]  mass_a, mass_b;
   logic [C-1:0]  radius_a, radius_b;
   logic [spcr_pkg::E_WIDTH-1:0] e_sat;
   logic [M+8:0]  m2e, m1e, m2x, m1x;
   logic [9:0]    e_plus;
   logic          en;

   // Stage one registers.
   logic                 v1_ff;
   logic signed [C:0]    d_ff [0:2];
   logic [C:0]           rsum_ff;
   logic signed [CW-1:0] c1a_ff, c2a_ff, c1b_ff, c2b_ff;
   logic [DW-1:0]        den_ff;
   logic                 zero_ff;
   logic [VW-1:0]        va1_ff, vb1_ff;

   // Stage two registers.
   logic                 v2_ff;
   logic [SW-1:0]        dsq_ff [0:2];
   logic [SW-1:0]        rsq_ff;
   logic signed [CW-1:0] c1a2_ff, c2a2_ff, c1b2_ff, c2b2_ff;
   logic [DW-1:0]        den2_ff;
   logic                 zero2_ff;
   logic [VW-1:0]        va2_ff, vb2_ff;

   logic [SW+1:0] dist2;
   logic          hit;

   assign pos_a    = in_data[VW-1:0];
   assign pos_b    = in_data[2*VW-1:VW];
   assign vel_a    = in_data[3*VW-1:2*VW];
   assign vel_b    = in_data[4*VW-1:3*VW];
   assign mass_a   = in_data[4*VW+M-1:4*VW];
   assign mass_b   = in_data[4*VW+2*M-1:4*VW+M];
   assign radius_a = in_data[4*VW+2*M+C-1:4*VW+2*M];
   assign radius_b = in_data[4*VW+2*M+2*C-1:4*VW+2*M+C];

   assign e_sat  = spcr_pkg::clamp_e(restitution);
   assign e_plus = 10'(spcr_pkg::E_ONE) + 10'(e_sat);
   assign m2e    = mass_b * e_sat;
   assign m1e    = mass_a * e_sat;
   assign m2x    = (M+9)'(mass_b * e_plus);
   assign m1x    = (M+9)'(mass_a * e_plus);

   assign en       = !(v2_ff && queue_full);
   assign in_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            d_ff[k] <= $signed({pos_a[k*C+C-1], pos_a[k*C +: C]})
                     - $signed({pos_b[k*C+C-1], pos_b[k*C +: C]});
            dsq_ff[k] <= SW'(d_ff[k] * d_ff[k]);
         end
         rsum_ff <= {1'b0, radius_a} + {1'b0, radius_b};
         c1a_ff  <= $signed({2'b00, mass_a, 8'd0}) - $signed({1'b0, m2e});
         c1b_ff  <= $signed({2'b00, mass_b, 8'd0}) - $signed({1'b0, m1e});
         c2a_ff  <= $signed({1'b0, m2x});
         c2b_ff  <= $signed({1'b0, m1x});
         den_ff  <= {({1'b0, mass_a} + {1'b0, mass_b}), 8'd0};
         zero_ff <= (mass_a == '0) && (mass_b == '0);
         va1_ff  <= vel_a;
         vb1_ff  <= vel_b;

         rsq_ff   <= SW'(rsum_ff * rsum_ff);
         c1a2_ff  <= c1a_ff;
         c2a2_ff  <= c2a_ff;
         c1b2_ff  <= c1b_ff;
         c2b2_ff  <= c2b_ff;
         den2_ff  <= den_ff;
         zero2_ff <= zero_ff;
         va2_ff   <= va1_ff;
         vb2_ff   <= vb1_ff;
      end
   end

   assign dist2 = (SW+2)'(dsq_ff[0]) + (SW+2)'(dsq_ff[1]) + (SW+2)'(dsq_ff[2]);
   assign hit   = dist2 <= (SW+2)'(rsq_ff);
   assign push  = v2_ff && !queue_full;
   assign entry = {hit, hit && !zero2_ff, den2_ff, c1a2_ff, c2a2_ff, c1b2_ff, c2b2_ff,
                   va2_ff, vb2_ff};

endmodule

>>> sv/spcr_queue.sv
// Short first-in first-out queue between the front and back parts.
module spcr_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = spcr_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             full,
   output logic             not_empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    count_ff, count_in;

   assign full      = count_ff == NW'(DEPTH);
   assign not_empty = count_ff != '0;
   assign dout      = mem[rd_ptr_ff];

   assign wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
   assign count_in  = count_ff + NW'(push) - NW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_in;
         if (pop)  rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem[wr_ptr_ff] <= din;
   end

endmodule

>>> sv/spcr_back.sv
// Back part: restitution products, pipelined division per axis and saturation.
module spcr_back #(
   parameter int C = spcr_pkg::COMPONENT_WIDTH,
   parameter int M = spcr_pkg::MASS_WIDTH,
   parameter int RSP_W = 96,
   parameter int EW = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             queue_valid,
   input  logic [EW-1:0]    entry,
   output logic             pop,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [RSP_W-1:0] out_data,
   output logic             out_hit
);
   localparam int CW = M + 10;
   localparam int DW = M + 9;
   localparam int VW = 3 * C;
   localparam int PW = CW + C;
   localparam int NW = M + C + 11;

   logic en;
   logic                 e_hit, e_upd;
   logic [DW-1:0]        e_den;
   logic signed [CW-1:0] e_c1a, e_c2a, e_c1b, e_c2b;
   logic [VW-1:0]        e_va, e_vb;

   // Product stage.
   logic                 pv_ff, phit_ff, pupd_ff;
   logic [DW-1:0]        pden_ff;
   logic [VW-1:0]        pva_ff, pvb_ff;
   logic signed [PW-1:0] pp_ff [0:5];
   logic signed [PW-1:0] pq_ff [0:5];

   // Divider stages; stage zero holds the magnitudes.
   logic          dv_ff   [0:C];
   logic          dhit_ff [0:C];
   logic          dupd_ff [0:C];
   logic [DW-1:0] dden_ff [0:C];
   logic [VW-1:0] dva_ff  [0:C];
   logic [VW-1:0] dvb_ff  [0:C];
   logic [NW-1:0] dr_ff   [0:C][0:5];
   logic [C-1:0]  dq_ff   [0:C][0:5];
   logic          dneg_ff [0:C][0:5];
   logic          dovf_ff [0:C][0:5];

   logic             out_valid_ff, hit_ff;
   logic [VW-1:0]    va_out_ff, vb_out_ff;
   logic [C-1:0]     res [0:5];
   logic [VW-1:0]    va_new, vb_new;

   assign {e_hit, e_upd, e_den, e_c1a, e_c2a, e_c1b, e_c2b, e_va, e_vb} = entry;

   assign en  = !out_valid_ff || out_ready;
   assign pop = en && queue_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int s = 0; s <= C; s++) dv_ff[s] <= 1'b0;
      end else if (en) begin
         pv_ff        <= queue_valid;
         dv_ff[0]     <= pv_ff;
         for (int s = 1; s <= C; s++) dv_ff[s] <= dv_ff[s-1];
         out_valid_ff <= dv_ff[C];
      end
   end

   // Lanes 0 to 2 give sphere A per axis, lanes 3 to 5 sphere B.
   always_ff @(posedge clock) begin
      if (en) begin
         phit_ff <= e_hit;
         pupd_ff <= e_upd;
         pden_ff <= e_den;
         pva_ff  <= e_va;
         pvb_ff  <= e_vb;
         for (int k = 0; k < 3; k++) begin
            pp_ff[k]   <= e_c1a * $signed(e_va[k*C +: C]);
            pq_ff[k]   <= e_c2a * $signed(e_vb[k*C +: C]);
            pp_ff[k+3] <= e_c1b * $signed(e_vb[k*C +: C]);
            pq_ff[k+3] <= e_c2b * $signed(e_va[k*C +: C]);
         end
      end
   end

   always_ff @(posedge clock) begin
      logic signed [NW-1:0] num;
      logic [NW-1:0]        mag;
      if (en) begin
         dhit_ff[0] <= phit_ff;
         dupd_ff[0] <= pupd_ff;
         dden_ff[0] <= pden_ff;
         dva_ff[0]  <= pva_ff;
         dvb_ff[0]  <= pvb_ff;
         for (int l = 0; l < 6; l++) begin
            num = NW'($signed({pp_ff[l][PW-1], pp_ff[l]}))
                + NW'($signed({pq_ff[l][PW-1], pq_ff[l]}));
            mag = num[NW-1] ? NW'(-num) : NW'(num);
            dr_ff[0][l]   <= mag;
            dq_ff[0][l]   <= '0;
            dneg_ff[0][l] <= num[NW-1];
            dovf_ff[0][l] <= mag >= ({{(NW-DW){1'b0}}, pden_ff} << C);
         end
      end
   end

   // One quotient bit per stage, most significant first.
   for (genvar s = 1; s <= C; s++) begin : g_div
      always_ff @(posedge clock) begin
         logic [NW-1:0] trial;
         if (en) begin
            dhit_ff[s] <= dhit_ff[s-1];
            dupd_ff[s] <= dupd_ff[s-1];
            dden_ff[s] <= dden_ff[s-1];
            dva_ff[s]  <= dva_ff[s-1];
            dvb_ff[s]  <= dvb_ff[s-1];
            trial = {{(NW-DW){1'b0}}, dden_ff[s-1]} << (C - s);
            for (int l = 0; l < 6; l++) begin
               dneg_ff[s][l] <= dneg_ff[s-1][l];
               dovf_ff[s][l] <= dovf_ff[s-1][l];
               if (dr_ff[s-1][l] >= trial) begin
                  dr_ff[s][l] <= dr_ff[s-1][l] - trial;
                  dq_ff[s][l] <= dq_ff[s-1][l] | (C'(1) << (C - s));
               end else begin
                  dr_ff[s][l] <= dr_ff[s-1][l];
                  dq_ff[s][l] <= dq_ff[s-1][l];
               end
            end
         end
      end
   end

   always_comb begin
      for (int l = 0; l < 6; l++) begin
         if (dneg_ff[C][l]) begin
            if (dovf_ff[C][l] || (dq_ff[C][l] > (C'(1) << (C - 1))))
               res[l] = C'(1) << (C - 1);
            else
               res[l] = C'(-dq_ff[C][l]);
         end else begin
            if (dovf_ff[C][l] || dq_ff[C][l][C-1])
               res[l] = ~(C'(1) << (C - 1));
            else
               res[l] = dq_ff[C][l];
         end
      end
      for (int k = 0; k < 3; k++) begin
         va_new[k*C +: C] = dupd_ff[C] ? res[k]   : dva_ff[C][k*C +: C];
         vb_new[k*C +: C] = dupd_ff[C] ? res[k+3] : dvb_ff[C][k*C +: C];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff    <= dhit_ff[C];
         va_out_ff <= va_new;
         vb_out_ff <= vb_new;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_hit   = hit_ff;
   assign out_data  = RSP_W'({vb_out_ff, va_out_ff});

endmodule

>>> sv/sphere_pair_collision_response_core.sv
// Top level of the sphere pair collision response core.
//
//   channel | ports            | payload
//   --------+------------------+-------------------------------------------------
//   request | req_t*           | tdata: pos_a, pos_b, vel_a, vel_b, mass_a, mass_b,
//           |                  |        radius_a, radius_b
//   result  | rsp_t*           | tdata: new_vel_a, new_vel_b; tuser: hit
//   config  | csr_valid/ready  | csr_wdata: restitution (Q1.8)
//
// One sphere pair is accepted per cycle while the queue is not full. The front part
// registers the distances and coefficients; the back part holds a product stage, the
// divider stages and an output register, its length set by the one-bit-per-stage divider.
// Reset is synchronous and clears all valid state; restitution returns to 205. A stalled
// result holds the back part; the front keeps accepting until the four-entry queue is full.
module sphere_pair_collision_response_core #(
   parameter int COMPONENT_WIDTH = spcr_pkg::COMPONENT_WIDTH,
   parameter int MASS_WIDTH      = spcr_pkg::MASS_WIDTH
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // pos_a, pos_b, vel_a, vel_b, mass_a, mass_b, radius_a, radius_b
   input  logic [((14*COMPONENT_WIDTH + 2*MASS_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // new_vel_a, new_vel_b
   output logic [((6*COMPONENT_WIDTH + 7) / 8) * 8 - 1:0] rsp_tdata,
   // hit
   output logic rsp_tuser,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [spcr_pkg::E_WIDTH-1:0] csr_wdata
);
   localparam int C     = COMPONENT_WIDTH;
   localparam int M     = MASS_WIDTH;
   localparam int REQ_W = ((14*C + 2*M + 7) / 8) * 8;
   localparam int RSP_W = ((6*C + 7) / 8) * 8;
   localparam int EW    = 2 + (M + 9) + 4 * (M + 10) + 6 * C;

   logic [spcr_pkg::E_WIDTH-1:0] restitution_ff;
   logic          push, pop, queue_full, queue_valid;
   logic [EW-1:0] entry_in, entry_out;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset)
         restitution_ff <= spcr_pkg::E_WIDTH'(spcr_pkg::RESTITUTION_RESET);
      else if (csr_valid)
         restitution_ff <= csr_wdata;
   end

   spcr_front #(.C(C), .M(M), .REQ_W(REQ_W), .EW(EW)) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_data     (req_tdata),
      .restitution (restitution_ff),
      .push        (push),
      .queue_full  (queue_full),
      .entry       (entry_in)
   );

   spcr_queue #(.WIDTH(EW), .DEPTH(spcr_pkg::QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .din       (entry_in),
      .pop       (pop),
      .dout      (entry_out),
      .full      (queue_full),
      .not_empty (queue_valid)
   );

   spcr_back #(.C(C), .M(M), .RSP_W(RSP_W), .EW(EW)) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_valid (queue_valid),
      .entry       (entry_out),
      .pop         (pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_data    (rsp_tdata),
      .out_hit     (rsp_tuser)
   );

endmodule

>>> sv/spcr_checker.sv
// Port-level checks for the sphere pair collision response core, with its bind.
module spcr_checker #(
   parameter int RSP_W = 96
) (
   input logic             clock,
   input logic             reset,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata,
   input logic             rsp_tuser,
   input logic             csr_ready
);

   // A stalled result keeps its data and flag.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // The front only stalls once the queue is full, which needs a waiting result.
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("request stalled without a waiting result");

   // No result may appear straight out of reset.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // Configuration writes are always taken.
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("configuration port not ready");

endmodule

bind sphere_pair_collision_response_core spcr_checker #(.RSP_W(RSP_W)) u_spcr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .csr_ready  (csr_ready)
);
